### rtl/core/ssid_pkg.sv
// Package for the sorted set store: sizes, codes and transaction types.
package ssid_pkg;

  // Store depth and derived widths
  localparam int unsigned Depth  = 16;
  localparam int unsigned IdxW   = $clog2(Depth);
  localparam int unsigned CntW   = $clog2(Depth + 1);

  // Fixed field widths
  localparam int unsigned KeyW   = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned EntryW = 5;
  localparam logic [PosW-1:0] PosMax = '1;

  // Request kinds
  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } req_type_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_CMP  = 1'b1
  } state_e;

  // Per-cell update operation
  typedef enum logic [1:0] {
    UPD_HOLD = 2'd0,
    UPD_INS  = 2'd1,
    UPD_DEL  = 2'd2
  } upd_e;

  // Command broadcast to every cell
  typedef struct packed {
    logic cmp;
    upd_e upd;
  } cell_cmd_t;

  // Request transaction
  typedef struct packed {
    req_type_e               req_type;
    logic signed [KeyW-1:0]  value;
  } req_t;

  // Result transaction
  typedef struct packed {
    status_e               status;
    logic [PosW-1:0]       position;
    logic [EntryW-1:0]     entry_count;
  } rsp_t;

endpackage

### rtl/core/ssid_cell.sv
// One storage cell of the sorted chain: holds a key, compares, shifts.
module ssid_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ssid_pkg::cell_cmd_t                cmd_i,
  input  logic signed [ssid_pkg::KeyW-1:0]   key_i,
  input  logic                               valid_i,
  input  logic signed [ssid_pkg::KeyW-1:0]   left_val_i,
  input  logic                               left_lt_i,
  input  logic signed [ssid_pkg::KeyW-1:0]   right_val_i,
  output logic signed [ssid_pkg::KeyW-1:0]   val_o,
  output logic                               lt_o,
  output logic                               eq_o
);

  logic signed [ssid_pkg::KeyW-1:0] val_q, val_d;
  logic lt_q, lt_d, eq_q, eq_d;

  // Compare flags, taken when a request arrives
  always_comb begin
    lt_d = lt_q;
    eq_d = eq_q;
    if (cmd_i.cmp) begin
      lt_d = valid_i && (val_q < key_i);
      eq_d = valid_i && (val_q == key_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  // Shift: cells below the key's place hold, the rest move one step
  always_comb begin
    val_d = val_q;
    case (cmd_i.upd)
      ssid_pkg::UPD_INS: begin
        if (!lt_q) begin
          val_d = left_lt_i ? key_i : left_val_i;
        end
      end
      ssid_pkg::UPD_DEL: begin
        if (!lt_q) begin
          val_d = right_val_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

### rtl/core/sorted_set_insert_delete.sv
// Top level of the sorted set store: request control and the cell chain.
//
// Keeps up to 16 signed 32-bit keys in ascending order without duplicates,
// in a chain of cells that each hold one key. When a request is accepted,
// every cell compares its key against the request key in parallel and
// registers less/equal flags; then, in the compare state, the position and
// hit are decoded from those flags and the cells shift up (insert) or down
// (delete) by one place from their neighbors, while the result is loaded
// into the output register. No new request is accepted until the current
// one has made its update; a waiting result holds the update step until
// the output register frees up. No clearing pass is needed after reset.
module sorted_set_insert_delete (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ssid_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ssid_pkg::rsp_t out_data_o
);

  localparam int unsigned Depth = ssid_pkg::Depth;
  localparam int unsigned CntW  = ssid_pkg::CntW;

  ssid_pkg::state_e state_q, state_d;
  ssid_pkg::req_type_e type_q;
  logic signed [ssid_pkg::KeyW-1:0] key_q, key_bus;
  logic [CntW-1:0] count_q, count_d;
  ssid_pkg::rsp_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic accept, do_upd, out_free;
  ssid_pkg::cell_cmd_t cmd;
  ssid_pkg::upd_e upd_sel;
  ssid_pkg::status_e status_w;

  logic signed [ssid_pkg::KeyW-1:0] val_w [Depth];
  logic [Depth-1:0] lt_w, eq_w, valid_w;
  logic [Depth:0]   lt_ext;
  logic [CntW-1:0]  pos_w;
  logic hit, full;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssid_pkg::S_IDLE: if (in_valid_i) state_d = ssid_pkg::S_CMP;
      ssid_pkg::S_CMP:  if (out_free)   state_d = ssid_pkg::S_IDLE;
      default:          state_d = ssid_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    accept     = 1'b0;
    do_upd     = 1'b0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ssid_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
      end
      ssid_pkg::S_CMP: begin
        do_upd = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // Request registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= in_data_i.value;
      type_q <= in_data_i.req_type;
    end
  end

  assign key_bus = (state_q == ssid_pkg::S_IDLE) ? in_data_i.value : key_q;

  // Occupied cells as a thermometer of the count
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      valid_w[i] = (CntW'(i) < count_q);
    end
  end

  // Position: the edge of the less-than thermometer
  always_comb begin
    lt_ext = {1'b0, lt_w};
    pos_w  = '0;
    for (int i = 0; i < Depth; i++) begin
      pos_w = pos_w | ((lt_ext[i] && !lt_ext[i+1]) ? CntW'(i + 1) : '0);
    end
  end

  assign hit  = |eq_w;
  assign full = (count_q == CntW'(Depth));

  // Decide the update and the result
  always_comb begin
    upd_sel  = ssid_pkg::UPD_HOLD;
    status_w = ssid_pkg::ST_NOT_FOUND;
    count_d  = count_q;
    if (type_q == ssid_pkg::REQ_INSERT) begin
      if (hit) begin
        status_w = ssid_pkg::ST_DUPLICATE;
      end else if (full) begin
        status_w = ssid_pkg::ST_FULL;
      end else begin
        status_w = ssid_pkg::ST_INSERTED;
        upd_sel  = ssid_pkg::UPD_INS;
        count_d  = count_q + CntW'(1);
      end
    end else begin
      if (hit) begin
        status_w = ssid_pkg::ST_REMOVED;
        upd_sel  = ssid_pkg::UPD_DEL;
        count_d  = count_q - CntW'(1);
      end
    end
  end

  assign cmd.cmp = accept;
  assign cmd.upd = do_upd ? upd_sel : ssid_pkg::UPD_HOLD;

  // Result register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (do_upd) begin
      out_d.status      = status_w;
      out_d.position    = (pos_w > CntW'(ssid_pkg::PosMax)) ? ssid_pkg::PosMax
                                                              : pos_w[ssid_pkg::PosW-1:0];
      out_d.entry_count = ssid_pkg::EntryW'(count_d);
      out_valid_d       = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssid_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (do_upd) begin
        count_q <= count_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Cell chain
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic signed [ssid_pkg::KeyW-1:0] left_val, right_val;
    logic left_lt;

    if (g == 0) begin : g_first
      assign left_val = key_bus;
      assign left_lt  = 1'b1;
    end else begin : g_mid
      assign left_val = val_w[g-1];
      assign left_lt  = lt_w[g-1];
    end

    if (g == Depth - 1) begin : g_last
      assign right_val = val_w[g];
    end else begin : g_inner
      assign right_val = val_w[g+1];
    end

    ssid_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .key_i       (key_bus),
      .valid_i     (valid_w[g]),
      .left_val_i  (left_val),
      .left_lt_i   (left_lt),
      .right_val_i (right_val),
      .val_o       (val_w[g]),
      .lt_o        (lt_w[g]),
      .eq_o        (eq_w[g])
    );
  end

endmodule

### test/sorted_set_insert_delete_test.sv
// Self-checking testbench for the sorted set store: directed table, then random requests.
module sorted_set_insert_delete_test;
  import ssid_pkg::*;

  localparam logic signed [KeyW-1:0] KeyMin = 32'sh8000_0000;
  localparam logic signed [KeyW-1:0] KeyMax = 32'sh7fff_ffff;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned PoolSize = 20;
  localparam int unsigned NumPhases = 32;
  localparam int unsigned PhaseItems = 48;
  localparam int unsigned NumRows = 26;

  // One row of the directed table; typed rows carry their own expected result
  typedef struct {
    req_type_e               op;
    logic signed [KeyW-1:0]  key;
    bit                      typed;
    status_e                 st;
    int unsigned             pos;
    int unsigned             cnt;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  req_t in_data = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_data_o;

  // Side channel to the monitor: typed expectation for the transaction on the input
  bit   row_typed = 1'b0;
  rsp_t row_want = '0;

  // Predictor state: ascending keys and fill count
  logic signed [KeyW-1:0] set_keys [Depth];
  int unsigned            key_count = 0;

  rsp_t        expected_rsps [$];
  rsp_t        head_rsp;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;

  logic signed [KeyW-1:0] key_pool [PoolSize];

  dir_row_t dir_rows [NumRows] = '{
    '{REQ_DELETE, 5,      1'b1, ST_NOT_FOUND, 0, 0},
    '{REQ_INSERT, 0,      1'b1, ST_INSERTED,  0, 1},
    '{REQ_INSERT, KeyMin, 1'b1, ST_INSERTED,  0, 2},
    '{REQ_INSERT, KeyMax, 1'b1, ST_INSERTED,  2, 3},
    '{REQ_INSERT, 0,      1'b1, ST_DUPLICATE, 1, 3},
    '{REQ_INSERT, -1,     1'b1, ST_INSERTED,  1, 4},
    '{REQ_DELETE, 1,      1'b1, ST_NOT_FOUND, 3, 4},
    '{REQ_INSERT, 700,    1'b0, ST_INSERTED,  0, 0},
    '{REQ_INSERT, 100,    1'b0, ST_INSERTED,  0, 0},
    '{REQ_INSERT, 1200,   1'b0, ST_INSERTED,  0, 0},
    '{REQ_INSERT, 400,    1'b0, ST_INSERTED,  0, 0},
    '{REQ_INSERT, 200,    1'b0, ST_INSERTED,  0, 0},
    '{REQ_INSERT, 1100,   1'b0, ST_INSERTED,  0, 0},
    '{REQ_INSERT, 300,    1'b0, ST_INSERTED,  0, 0},
    '{REQ_INSERT, 900,    1'b0, ST_INSERTED,  0, 0},
    '{REQ_INSERT, 500,    1'b0, ST_INSERTED,  0, 0},
    '{REQ_INSERT, 1000,   1'b0, ST_INSERTED,  0, 0},
    '{REQ_INSERT, 600,    1'b0, ST_INSERTED,  0, 0},
    '{REQ_INSERT, 800,    1'b0, ST_INSERTED,  0, 0},
    // store is full here
    '{REQ_INSERT, 50,     1'b1, ST_FULL,      3, 16},
    '{REQ_INSERT, KeyMax, 1'b1, ST_DUPLICATE, 15, 16},
    '{REQ_DELETE, KeyMax, 1'b1, ST_REMOVED,   15, 15},
    '{REQ_INSERT, 2000,   1'b1, ST_INSERTED,  15, 16},
    // would land past the last slot: position saturates
    '{REQ_INSERT, 3000,   1'b1, ST_FULL,      15, 16},
    '{REQ_DELETE, KeyMin, 1'b1, ST_REMOVED,   0, 15},
    '{REQ_DELETE, KeyMin, 1'b1, ST_NOT_FOUND, 0, 15}
  };

  sorted_set_insert_delete DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Apply one request to the predicted set and return the result it produces
  function automatic rsp_t apply_request(input req_t r);
    logic signed [KeyW-1:0] key;
    int unsigned            slot;
    int unsigned            n;
    bit                     hit;
    status_e                st;
    rsp_t                   res;
    key  = r.value;
    n    = key_count;
    slot = 0;
    while (slot < n && $signed(set_keys[slot]) < $signed(key)) slot++;
    hit = (slot < n) && (set_keys[slot] == key);
    if (r.req_type == REQ_INSERT) begin
      if (hit) begin
        st = ST_DUPLICATE;
      end else if (n >= Depth) begin
        st = ST_FULL;
      end else begin
        for (int i = n; i > slot; i--) set_keys[i] = set_keys[i-1];
        set_keys[slot] = key;
        n++;
        st = ST_INSERTED;
      end
    end else begin
      if (hit) begin
        for (int i = slot; i + 1 < n; i++) set_keys[i] = set_keys[i+1];
        n--;
        st = ST_REMOVED;
      end else begin
        st = ST_NOT_FOUND;
      end
    end
    key_count       = n;
    res.status      = st;
    res.position    = (slot > 15) ? PosMax : PosW'(slot);
    res.entry_count = (n > 31) ? 5'd31 : EntryW'(n);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Mostly short gaps, a few long ones; none during quiet stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one transaction, hold it until accepted, then maybe idle
  task automatic send_request(input req_t r, input bit typed, input rsp_t want);
    int unsigned gap;
    in_valid  <= 1'b1;
    in_data   <= r;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk_i); while (in_stall_o);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Fresh key pool per phase: extremes, a tight cluster and wide values
  task automatic refill_pool();
    for (int i = 0; i < PoolSize; i++) begin
      case (i)
        0: key_pool[i] = KeyMin;
        1: key_pool[i] = KeyMax;
        2: key_pool[i] = 0;
        3: key_pool[i] = -1;
        default: begin
          if (i % 2 == 0) key_pool[i] = $urandom;
          else key_pool[i] = int'($urandom_range(0, 64)) - 32;
        end
      endcase
    end
  endtask

  // Receiver: random stall pattern, no stalls during quiet stretches
  initial begin
    int unsigned run;
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      run = $urandom_range(1, 12);
      out_stall_i <= 1'b0;
      repeat (run) @(posedge clk_i);
      hold = pick_gap();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  // Monitor: check results against the oldest expectation, predict accepted requests
  always @(posedge clk_i) begin
    if ((out_valid_o && !out_stall_i) || (in_valid && !in_stall_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (out_valid_o && !out_stall_i) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("result with nothing expected", 1, 0);
      end else begin
        head_rsp = expected_rsps.pop_front();
        if (out_data_o.status !== head_rsp.status)
          report_mismatch("status", out_data_o.status, head_rsp.status);
        if (out_data_o.position !== head_rsp.position)
          report_mismatch("position", out_data_o.position, head_rsp.position);
        if (out_data_o.entry_count !== head_rsp.entry_count)
          report_mismatch("entry_count", out_data_o.entry_count, head_rsp.entry_count);
      end
    end
    if (in_valid && !in_stall_o) begin
      head_rsp = apply_request(in_data);
      expected_rsps.push_back(row_typed ? row_want : head_rsp);
    end
    if (idle_cycles >= IdleLimit) begin
      $display("sorted_set_insert_delete verification failed");
      $finish;
    end
  end

  // Stimulus and verdict
  initial begin
    req_t        req;
    rsp_t        want;
    bit          grow;
    int unsigned r;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int i = 0; i < NumRows; i++) begin
      req.req_type     = dir_rows[i].op;
      req.value        = dir_rows[i].key;
      want.status      = dir_rows[i].st;
      want.position    = PosW'(dir_rows[i].pos);
      want.entry_count = EntryW'(dir_rows[i].cnt);
      send_request(req, dir_rows[i].typed, want);
    end

    // Random phases alternating between filling and draining the set
    want = '0;
    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase % 8 == 7) begin
        in_valid <= 1'b0;
        while (expected_rsps.size() != 0) @(negedge clk_i);
        @(posedge clk_i);
      end
      quiet = (phase % 5 == 3);
      grow  = (phase % 2 == 0);
      refill_pool();
      for (int k = 0; k < PhaseItems; k++) begin
        r = $urandom_range(0, 99);
        req.req_type = (r < (grow ? 75 : 30)) ? REQ_INSERT : REQ_DELETE;
        r = $urandom_range(0, 99);
        if (r < 15) req.value = $urandom;
        else if (req.req_type == REQ_DELETE && r < 55 && key_count > 0)
          req.value = set_keys[$urandom_range(0, key_count - 1)];
        else req.value = key_pool[$urandom_range(0, PoolSize - 1)];
        send_request(req, 1'b0, want);
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // Drain, then allow the block's latency to settle
    while (expected_rsps.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (expected_rsps.size() != 0)
      report_mismatch("results never delivered", 0, expected_rsps.size());
    if (mismatches == 0) begin
      $display("sorted_set_insert_delete verification clean");
    end else begin
      $display("sorted_set_insert_delete verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/ssid_pkg.sv
rtl/core/ssid_cell.sv
rtl/core/sorted_set_insert_delete.sv
test/sorted_set_insert_delete_test.sv
